[rtl/core/ross_pkg.sv]
package ross_pkg;

  localparam int NODES      = 1024;
  localparam int COUNT_BITS = 8;
  localparam int NODE_BITS  = $clog2(NODES);
  localparam int SIZE_BITS  = NODE_BITS + 1;
  localparam int CF_BITS    = COUNT_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [NODE_BITS-1:0]  LAST_NODE = NODE_BITS'(NODES - 1);

  // operation codes
  localparam logic [2:0] KIND_RIM      = 3'd0;
  localparam logic [2:0] KIND_UNRIM    = 3'd1;
  localparam logic [2:0] KIND_OCCUPY   = 3'd2;
  localparam logic [2:0] KIND_UNOCCUPY = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;

  // result status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SATURATED = 3'd1;
  localparam logic [2:0] STATUS_UNDERFLOW = 3'd2;
  localparam logic [2:0] STATUS_NOT_OCC   = 3'd3;
  localparam logic [2:0] STATUS_BEYOND    = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_WB
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic                 req_stall;
    logic                 accept;
    logic                 ex;
    logic                 wb;
    logic                 wb_done;
    logic                 clearing;
    logic [NODE_BITS-1:0] clr_addr;
  } ctl_t;

endpackage

[rtl/core/ross_ram.sv]
module ross_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ross_ctrl.sv]
module ross_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            out_free,
  output ross_pkg::ctl_t  ctl
);

  ross_pkg::state_t                 state, state_next;
  logic [ross_pkg::NODE_BITS-1:0]   clr_addr, clr_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ross_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    ctl           = '0;
    ctl.req_stall = 1'b1;
    ctl.clr_addr  = clr_addr;
    case (state)
      ross_pkg::ST_CLEAR: begin
        ctl.clearing  = 1'b1;
        clr_addr_next = clr_addr + (ross_pkg::NODE_BITS)'(1);
        if (clr_addr == ross_pkg::LAST_NODE) begin
          state_next = ross_pkg::ST_IDLE;
        end
      end
      ross_pkg::ST_IDLE: begin
        ctl.req_stall = 1'b0;
        if (req_valid) begin
          ctl.accept = 1'b1;
          state_next = ross_pkg::ST_RD;
        end
      end
      ross_pkg::ST_RD: begin
        state_next = ross_pkg::ST_EX;
      end
      ross_pkg::ST_EX: begin
        ctl.ex     = 1'b1;
        state_next = ross_pkg::ST_WB;
      end
      ross_pkg::ST_WB: begin
        ctl.wb = 1'b1;
        if (out_free) begin
          ctl.wb_done = 1'b1;
          state_next  = ross_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ross_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/rim_occupy_sparse_set_core.sv]
// Each item passes through accept, memory read, modify/write and write-back; no new
//   request is accepted until the write-back is done, which waits for a free output register,
//   as the count, position and list tail must be read before the swap-remove.
// Reset: synchronous; list sizes clear at once, then a pass zeroes all 1024 count/flag
//   memory entries one entry per cycle with req_stall held high.
module rim_occupy_sparse_set_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [2:0]                          kind,
  input  logic [ross_pkg::NODE_BITS-1:0]      node,
  input  logic                                list_select,
  input  logic [ross_pkg::NODE_BITS-1:0]      position,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [2:0]                          status,
  output logic [ross_pkg::COUNT_BITS-1:0]     rim_count,
  output logic                                occupied,
  output logic [ross_pkg::SIZE_BITS-1:0]      rim_size,
  output logic [ross_pkg::SIZE_BITS-1:0]      occupied_size,
  output logic [ross_pkg::NODE_BITS-1:0]      entry
);

  localparam int NB = ross_pkg::NODE_BITS;
  localparam int SB = ross_pkg::SIZE_BITS;
  localparam int CB = ross_pkg::COUNT_BITS;

  ross_pkg::ctl_t ctl;
  logic           out_free;

  assign out_free  = !res_valid || !res_stall;
  assign req_stall = ctl.req_stall;

  ross_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  // Latched request item
  logic [2:0]    kind_r;
  logic [NB-1:0] node_r;
  logic          sel_r;
  logic [NB-1:0] pos_r;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      kind_r <= kind;
      node_r <= node;
      sel_r  <= list_select;
      pos_r  <= position;
    end
  end

  // List sizes live in flops; tail address is size - 1 (wraps when empty, unused then)
  logic [SB-1:0] rim_sz, rim_sz_next;
  logic [SB-1:0] occ_sz, occ_sz_next;
  logic [SB-1:0] rim_tail, occ_tail;

  assign rim_tail = rim_sz - SB'(1);
  assign occ_tail = occ_sz - SB'(1);

  // Memories: count+flag per node, position per node, and the two member lists.
  logic          cf_we;
  logic [NB-1:0] cf_waddr;
  logic [ross_pkg::CF_BITS-1:0] cf_wdata, cf_q;

  logic          pos_we;
  logic [NB-1:0] pos_waddr, pos_wdata, pos_q;

  logic          rim_we, occ_we;
  logic [NB-1:0] rim_waddr, rim_wdata, rim_raddr, rim_q;
  logic [NB-1:0] occ_waddr, occ_wdata, occ_raddr, occ_q;

  assign rim_raddr = (kind_r == ross_pkg::KIND_READ) ? pos_r : rim_tail[NB-1:0];
  assign occ_raddr = (kind_r == ross_pkg::KIND_READ) ? pos_r : occ_tail[NB-1:0];

  ross_ram #(.DEPTH(ross_pkg::NODES), .WIDTH(ross_pkg::CF_BITS)) u_cf_ram (
    .clk (clk), .we (cf_we), .waddr (cf_waddr), .wdata (cf_wdata),
    .raddr (node_r), .rdata (cf_q)
  );

  ross_ram #(.DEPTH(ross_pkg::NODES), .WIDTH(NB)) u_pos_ram (
    .clk (clk), .we (pos_we), .waddr (pos_waddr), .wdata (pos_wdata),
    .raddr (node_r), .rdata (pos_q)
  );

  ross_ram #(.DEPTH(ross_pkg::NODES), .WIDTH(NB)) u_rim_ram (
    .clk (clk), .we (rim_we), .waddr (rim_waddr), .wdata (rim_wdata),
    .raddr (rim_raddr), .rdata (rim_q)
  );

  ross_ram #(.DEPTH(ross_pkg::NODES), .WIDTH(NB)) u_occ_ram (
    .clk (clk), .we (occ_we), .waddr (occ_waddr), .wdata (occ_wdata),
    .raddr (occ_raddr), .rdata (occ_q)
  );

  // Modify step: decide count/flag update and list moves from the read data.
  logic [CB-1:0] cnt, new_cnt;
  logic          occ, new_occ;
  logic [2:0]    ex_status;
  logic [NB-1:0] ex_entry;
  logic          rm_rim, rm_occ, ap_rim, ap_occ;

  assign cnt = cf_q[CB-1:0];
  assign occ = cf_q[CB];

  always_comb begin
    new_cnt   = cnt;
    new_occ   = occ;
    ex_status = ross_pkg::STATUS_OK;
    ex_entry  = '0;
    rm_rim    = 1'b0;
    rm_occ    = 1'b0;
    ap_rim    = 1'b0;
    ap_occ    = 1'b0;
    case (kind_r)
      ross_pkg::KIND_RIM: begin
        if (cnt == ross_pkg::COUNT_MAX) begin
          ex_status = ross_pkg::STATUS_SATURATED;
        end else begin
          new_cnt = cnt + CB'(1);
          ap_rim  = (cnt == '0) && !occ;
        end
      end
      ross_pkg::KIND_UNRIM: begin
        if (cnt == '0) begin
          ex_status = ross_pkg::STATUS_UNDERFLOW;
        end else begin
          new_cnt = cnt - CB'(1);
          rm_rim  = (new_cnt == '0) && !occ;
        end
      end
      ross_pkg::KIND_OCCUPY: begin
        if (!occ) begin
          rm_rim  = (cnt != '0);
          ap_occ  = 1'b1;
          new_occ = 1'b1;
        end
      end
      ross_pkg::KIND_UNOCCUPY: begin
        if (!occ) begin
          ex_status = ross_pkg::STATUS_NOT_OCC;
        end else begin
          new_occ = 1'b0;
          rm_occ  = 1'b1;
          ap_rim  = (cnt != '0);
        end
      end
      ross_pkg::KIND_READ: begin
        if (!sel_r) begin
          if ({1'b0, pos_r} < rim_sz) ex_entry = rim_q;
          else                        ex_status = ross_pkg::STATUS_BEYOND;
        end else begin
          if ({1'b0, pos_r} < occ_sz) ex_entry = occ_q;
          else                        ex_status = ross_pkg::STATUS_BEYOND;
        end
      end
      default: begin
      end
    endcase
  end

  // Write ports. Swap-remove writes the tail into the hole and fixes the tail's
  // position now; the appended node's position is written in the cycle after, in write-back, so it
  // wins when the removed tail is the node itself.
  logic          ap_pend;
  logic [NB-1:0] ap_idx;

  always_comb begin
    cf_we    = ctl.clearing || ctl.ex;
    cf_waddr = ctl.clearing ? ctl.clr_addr : node_r;
    cf_wdata = ctl.clearing ? '0 : {new_occ, new_cnt};

    rim_we    = ctl.ex && (rm_rim || ap_rim);
    rim_waddr = rm_rim ? pos_q : rim_sz[NB-1:0];
    rim_wdata = rm_rim ? rim_q : node_r;

    occ_we    = ctl.ex && (rm_occ || ap_occ);
    occ_waddr = rm_occ ? pos_q : occ_sz[NB-1:0];
    occ_wdata = rm_occ ? occ_q : node_r;

    if (ctl.ex) begin
      pos_we    = rm_rim || rm_occ;
      pos_waddr = rm_rim ? rim_q : occ_q;
      pos_wdata = pos_q;
    end else begin
      pos_we    = ctl.wb && ap_pend;
      pos_waddr = node_r;
      pos_wdata = ap_idx;
    end

    rim_sz_next = rim_sz;
    occ_sz_next = occ_sz;
    if (ctl.ex) begin
      rim_sz_next = rim_sz + SB'(ap_rim) - SB'(rm_rim);
      occ_sz_next = occ_sz + SB'(ap_occ) - SB'(rm_occ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rim_sz  <= '0;
      occ_sz  <= '0;
      ap_pend <= 1'b0;
    end else begin
      rim_sz <= rim_sz_next;
      occ_sz <= occ_sz_next;
      if (ctl.ex) begin
        ap_pend <= ap_rim || ap_occ;
      end
    end
  end

  // Staged result, then the output register
  logic [2:0]    st_status;
  logic [CB-1:0] st_cnt;
  logic          st_occ;
  logic [NB-1:0] st_entry;

  always_ff @(posedge clk) begin
    if (ctl.ex) begin
      st_status <= ex_status;
      st_cnt    <= new_cnt;
      st_occ    <= new_occ;
      st_entry  <= ex_entry;
      ap_idx    <= ap_rim ? rim_sz[NB-1:0] : occ_sz[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.wb_done) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wb_done) begin
      status        <= st_status;
      rim_count     <= st_cnt;
      occupied      <= st_occ;
      rim_size      <= rim_sz;
      occupied_size <= occ_sz;
      entry         <= st_entry;
    end
  end

  // A node sits in at most one list, so the two sizes never exceed the node count.
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    (rim_sz + occ_sz) <= (SB + 1)'(ross_pkg::NODES))
    else $error("list sizes exceed node count");

  // Never remove from and append to the same list in one operation.
  a_one_move_per_list: assert property (@(posedge clk) disable iff (rst)
    ctl.ex |-> !(rm_rim && ap_rim) && !(rm_occ && ap_occ))
    else $error("remove and append on one list");

  // A removal only ever hits a non-empty list.
  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.ex && (rm_rim || rm_occ) |-> (rm_rim ? rim_sz != '0 : occ_sz != '0))
    else $error("remove from empty list");

  // An accepted item passes through the read state straight to the modify step.
  a_accept_to_ex: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |-> ##2 ctl.ex)
    else $error("sequencer skipped modify step");

  // The clearing pass never overlaps an item.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.clearing |-> !ctl.accept && !ctl.ex && !ctl.wb)
    else $error("item active during clear");

endmodule
